// ===== design/alked_pkg.sv =====
// Shared types and constants for the ladder keypad event decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package alked_pkg;

	// Key code for "no key pressed"
	localparam logic [2:0] NO_KEY = 3'd7;
	localparam int unsigned LADDER_KEYS = 7;
	localparam int unsigned THRESH_BITS = 16;

	// Event kinds
	localparam logic [1:0] EV_RELEASE = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_LONG    = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_KEY_MASK  = 2'd0;
	localparam logic [1:0] CFG_CMD_TABLE = 2'd1;
	localparam logic [1:0] CFG_LONG_TICKS = 2'd2;

	localparam logic [7:0] LONG_TICKS_RST = 8'd10;

	typedef struct packed {
		logic [6:0]  key_mask;
		logic [55:0] cmd_table;
		logic [7:0]  long_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] key;
		logic [7:0] cmd;
	} event_t;

	// Events caused by one sample: ev0 always, ev1 only when two is set
	typedef struct packed {
		logic   two;
		event_t ev0;
		event_t ev1;
	} pair_t;

	// Ladder thresholds, key i selected by the first one above the sample
	function automatic logic [THRESH_BITS-1:0] key_thresh(input logic [2:0] idx);
		logic [THRESH_BITS-1:0] t;
		case (idx)
			3'd0: t = 16'd100;
			3'd1: t = 16'd300;
			3'd2: t = 16'd450;
			3'd3: t = 16'd550;
			3'd4: t = 16'd600;
			3'd5: t = 16'd670;
			3'd6: t = 16'd1000;
			default: t = 16'd1000;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== design/alked_cfg.sv =====
// Configuration register bank for the ladder keypad decoder.
// Depends on alked_pkg for the register index codes and cfg_t.
`default_nettype none
module alked_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [1:0]    wr_index,
	input  wire logic [55:0]   wr_data,
	output alked_pkg::cfg_t    cfg
);
	import alked_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_mask   <= '0;
			cfg_q.cmd_table  <= '0;
			cfg_q.long_ticks <= LONG_TICKS_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_KEY_MASK:   cfg_q.key_mask   <= wr_data[6:0];
				CFG_CMD_TABLE:  cfg_q.cmd_table  <= wr_data;
				CFG_LONG_TICKS: cfg_q.long_ticks <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== design/alked_front.sv =====
// Front end: takes samples, decodes the key, tracks hold state and
// classifies each sample into zero, one or two events. Uses alked_pkg.
`default_nettype none
module alked_front #(
	parameter int unsigned NUM_KEYS = 7,
	parameter int unsigned ADC_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ADC_BITS-1:0] adc_sample,
	input  wire alked_pkg::cfg_t     cfg,
	input  wire logic                q_full,
	output logic                     push,
	output alked_pkg::pair_t         push_data
);
	import alked_pkg::*;

	logic [2:0] prev_key_q;
	logic [7:0] hold_cnt_q;
	logic       hold_off_q;

	logic [THRESH_BITS-1:0] sample_ext;
	logic [2:0] key;
	logic       accept;
	logic       changed, en_prev, en_key, below;
	logic       do_rel, do_press, do_long;

	function automatic logic [7:0] key_cmd(input logic [55:0] tbl, input logic [2:0] k);
		logic [7:0] c;
		c = '0;
		for (int i = 0; i < LADDER_KEYS; i++) begin
			if (k == 3'(i))
				c = tbl[8*i +: 8];
		end
		return c;
	endfunction

	// Threshold compares, lowest matching key wins
	always_comb begin
		sample_ext = THRESH_BITS'(adc_sample);
		key = NO_KEY;
		for (int i = LADDER_KEYS - 1; i >= 0; i--) begin
			if (i < NUM_KEYS && sample_ext < key_thresh(3'(i)))
				key = 3'(i);
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Event classification
	always_comb begin
		changed  = (key != prev_key_q);
		en_prev  = (prev_key_q != NO_KEY) && cfg.key_mask[prev_key_q];
		en_key   = (key != NO_KEY) && cfg.key_mask[key];
		below    = (hold_cnt_q < cfg.long_ticks);
		do_rel   = changed && en_prev && !hold_off_q;
		do_press = changed && en_key;
		do_long  = !changed && (key != NO_KEY) && !hold_off_q && !below && en_key;
	end

	always_comb begin
		push_data.two = do_rel && do_press;
		push_data.ev1.kind = EV_PRESS;
		push_data.ev1.key  = key;
		push_data.ev1.cmd  = key_cmd(cfg.cmd_table, key);
		if (do_rel) begin
			push_data.ev0.kind = EV_RELEASE;
			push_data.ev0.key  = prev_key_q;
			push_data.ev0.cmd  = key_cmd(cfg.cmd_table, prev_key_q);
		end else begin
			push_data.ev0.kind = do_press ? EV_PRESS : EV_LONG;
			push_data.ev0.key  = key;
			push_data.ev0.cmd  = key_cmd(cfg.cmd_table, key);
		end
	end

	assign push = accept && (do_rel || do_press || do_long);

	// Hold state update per accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q <= NO_KEY;
			hold_cnt_q <= '0;
			hold_off_q <= 1'b0;
		end else if (accept) begin
			if (changed) begin
				if (en_key) begin
					hold_cnt_q <= '0;
					hold_off_q <= 1'b0;
				end else if (en_prev) begin
					hold_off_q <= 1'b1;
				end
				prev_key_q <= key;
			end else if (key != NO_KEY && !hold_off_q) begin
				if (below)
					hold_cnt_q <= hold_cnt_q + 8'd1;
				else if (en_key)
					hold_off_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/alked_queue.sv =====
// Two-entry queue of event pairs between front and back ends.
// Uses alked_pkg for pair_t.
`default_nettype none
module alked_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire alked_pkg::pair_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output alked_pkg::pair_t      head
);
	import alked_pkg::*;

	pair_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/alked_back.sv =====
// Back end: splits queued event pairs into single events and holds
// each in the output register until taken. Uses alked_pkg.
`default_nettype none
module alked_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             not_empty,
	input  wire alked_pkg::pair_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            event_kind,
	output logic [2:0]            key_index,
	output logic [7:0]            command,
	output logic                  last_event
);
	import alked_pkg::*;

	logic   second_q;
	logic   out_valid_q;
	event_t ev_q;
	logic   last_q;
	logic   load;

	assign load = not_empty && (!out_valid_q || !out_stall);
	assign pop  = load && (second_q || !head.two);

	// Which half of the head pair goes out next, and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				second_q <= !second_q && head.two;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			ev_q   <= second_q ? head.ev1 : head.ev0;
			last_q <= second_q || !head.two;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = ev_q.kind;
	assign key_index  = ev_q.key;
	assign command    = ev_q.cmd;
	assign last_event = last_q;

endmodule
`default_nettype wire

// ===== design/adc_ladder_key_event_decoder.sv =====
// Top level of the resistor-ladder keypad event decoder.
// Depends on alked_pkg, alked_cfg, alked_front, alked_queue, alked_back.
//
// Usage:
//  - Input channel (in_valid/in_stall/adc_sample): one sample per tick.
//    A sample is taken at an edge with in_valid high and in_stall low.
//  - Output channel (out_valid/out_stall/...): release, press or long-press
//    events, one per transaction; last_event marks the final event of a sample.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
//    always high; write only while no events are pending.
// Timing: one sample per cycle is accepted while in_stall is low; a sample causing
//    events passes through the pair queue and then the output register before its
//    first event shows. Sustained output is one event per cycle while out_stall is
//    low, set by the single output register; a sample causing two events takes two
//    output transactions, so the two-entry pair queue may fill and raise in_stall.
// Reset: key state goes to "no key", hold counter active, enable mask and
//    command table clear, long-press ticks 10, queue and output empty.
// When the receiver stalls, the output event holds, the queue fills, and
//    then in_stall rises until space frees up.
`default_nettype none
module adc_ladder_key_event_decoder #(
	parameter int unsigned NUM_KEYS = 7,
	parameter int unsigned ADC_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ADC_BITS-1:0] adc_sample,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               event_kind,
	output logic [2:0]               key_index,
	output logic [7:0]               command,
	output logic                     last_event,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [55:0]         cfg_data
);
	import alked_pkg::*;

	cfg_t  cfg;
	pair_t push_data, head;
	logic  push, pop, q_full, q_not_empty;

	assign cfg_ready = 1'b1;

	alked_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	alked_front #(
		.NUM_KEYS (NUM_KEYS),
		.ADC_BITS (ADC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.cfg        (cfg),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	alked_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	alked_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (q_not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.key_index  (key_index),
		.command    (command),
		.last_event (last_event)
	);

endmodule
`default_nettype wire
